// ===== src/fct_pkg.sv =====
// fault code table package: sizes, codes and transaction types
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

    // table size and derived widths
    localparam int DEPTH     = 8;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CODE_W    = 16;
    localparam int OCC_W     = 8;
    localparam int TOTAL_W   = 7;

    // operation codes
    localparam logic [1:0] OP_STORE     = 2'd0;
    localparam logic [1:0] OP_CLEAR     = 2'd1;
    localparam logic [1:0] OP_CLEAR_ALL = 2'd2;
    localparam logic [1:0] OP_QUERY     = 2'd3;

    // status codes
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_EXISTS    = 3'd1;
    localparam logic [2:0] STS_FULL      = 3'd2;
    localparam logic [2:0] STS_INVALID   = 3'd3;
    localparam logic [2:0] STS_NOT_FOUND = 3'd4;

    localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};

    // input transaction
    typedef struct packed {
        logic [1:0]        op;
        logic [CODE_W-1:0] code;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic [2:0]         status;
        logic               hit_active;
        logic [OCC_W-1:0]   occurrences;
        logic [TOTAL_W-1:0] entry_total;
    } out_item_t;

    // one stored table entry
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [OCC_W-1:0]  occ;
        logic              active;
    } entry_t;

    // memory access from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_cmd_t;

endpackage

`default_nettype wire

// ===== src/fct_ram.sv =====
// fault code table entry store: simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module fct_ram #(
    parameter int WIDTH  = 25,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/fct_ctrl.sv =====
// fault code table sequencer: scan, read-modify-write and result register
`timescale 1ns / 1ps
`default_nettype none

module fct_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire fct_pkg::in_item_t         s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output fct_pkg::out_item_t             m_data,
    input  wire logic [fct_pkg::CODE_W-1:0] reserved_code,
    output fct_pkg::mem_cmd_t              mem_cmd,
    input  wire fct_pkg::entry_t           rd_data
);

    import fct_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic              found_reg, found_next;
    logic              m_valid_reg, m_valid_next;

    logic [1:0]        op_reg, op_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [ADDR_W-1:0] data_addr_reg, data_addr_next;
    logic [ADDR_W-1:0] hit_addr_reg, hit_addr_next;
    entry_t            hit_reg, hit_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic              res_active_reg, res_active_next;
    logic [OCC_W-1:0]  res_occ_reg, res_occ_next;
    out_item_t         m_data_reg, m_data_next;

    logic [CNT_W-1:0]  last_idx;
    logic [OCC_W-1:0]  occ_inc;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign last_idx = count_reg - 1'b1;
    assign occ_inc  = (hit_reg.occ == OCC_MAX) ? OCC_MAX : hit_reg.occ + 1'b1;

    // next state and memory access
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        m_valid_next    = m_valid_reg;
        op_next         = op_reg;
        code_next       = code_reg;
        data_addr_next  = data_addr_reg;
        hit_addr_next   = hit_addr_reg;
        hit_next        = hit_reg;
        res_status_next = res_status_reg;
        res_active_next = res_active_reg;
        res_occ_next    = res_occ_reg;
        m_data_next     = m_data_reg;
        mem_cmd         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.op;
                    code_next  = s_data.code;
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    if (s_data.op == OP_CLEAR_ALL) begin
                        count_next      = '0;
                        res_status_next = STS_OK;
                        res_active_next = 1'b0;
                        res_occ_next    = '0;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            // linear search, one read issued per cycle
            S_SCAN: begin
                if (pend_reg && rd_data.code == code_reg) begin
                    found_next    = 1'b1;
                    hit_addr_next = data_addr_reg;
                    hit_next      = rd_data;
                    pend_next     = 1'b0;
                    state_next    = S_ACT;
                end else if (ptr_reg < count_reg) begin
                    mem_cmd.rd_en  = 1'b1;
                    mem_cmd.rd_addr = ptr_reg[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    data_addr_next = ptr_reg[ADDR_W-1:0];
                    ptr_next       = ptr_reg + 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_ACT;
                end
            end

            // apply the operation
            S_ACT: begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_STORE: begin
                        if (code_reg == reserved_code) begin
                            // rejected, a stored entry with this code is still reported
                            res_status_next = STS_INVALID;
                            res_active_next = found_reg && hit_reg.active;
                            res_occ_next    = found_reg ? hit_reg.occ : '0;
                        end else if (found_reg) begin
                            mem_cmd.wr_en          = 1'b1;
                            mem_cmd.wr_addr        = hit_addr_reg;
                            mem_cmd.wr_data.code   = code_reg;
                            mem_cmd.wr_data.occ    = occ_inc;
                            mem_cmd.wr_data.active = 1'b1;
                            res_status_next        = STS_EXISTS;
                            res_active_next        = 1'b1;
                            res_occ_next           = occ_inc;
                        end else if (count_reg == CNT_W'(DEPTH)) begin
                            res_status_next = STS_FULL;
                            res_active_next = 1'b0;
                            res_occ_next    = '0;
                        end else begin
                            mem_cmd.wr_en          = 1'b1;
                            mem_cmd.wr_addr        = count_reg[ADDR_W-1:0];
                            mem_cmd.wr_data.code   = code_reg;
                            mem_cmd.wr_data.occ    = OCC_W'(1);
                            mem_cmd.wr_data.active = 1'b1;
                            count_next             = count_reg + 1'b1;
                            res_status_next        = STS_OK;
                            res_active_next        = 1'b1;
                            res_occ_next           = OCC_W'(1);
                        end
                    end
                    OP_CLEAR: begin
                        res_active_next = 1'b0;
                        res_occ_next    = '0;
                        if (found_reg) begin
                            // the last entry fills the hole, entries stay contiguous
                            count_next      = last_idx;
                            res_status_next = STS_OK;
                            if (hit_addr_reg != last_idx[ADDR_W-1:0]) begin
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr = last_idx[ADDR_W-1:0];
                                state_next      = S_MOVE;
                            end
                        end else begin
                            res_status_next = STS_NOT_FOUND;
                        end
                    end
                    default: begin
                        if (found_reg) begin
                            res_status_next = STS_OK;
                            res_active_next = hit_reg.active;
                            res_occ_next    = hit_reg.occ;
                        end else begin
                            res_status_next = STS_NOT_FOUND;
                            res_active_next = 1'b0;
                            res_occ_next    = '0;
                        end
                    end
                endcase
            end

            // write the moved entry into the freed slot
            S_MOVE: begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = hit_addr_reg;
                mem_cmd.wr_data = rd_data;
                state_next      = S_DONE;
            end

            // hand the result to the output register
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = res_status_reg;
                    m_data_next.hit_active  = res_active_reg;
                    m_data_next.occurrences = res_occ_reg;
                    m_data_next.entry_total = TOTAL_W'(count_reg);
                    state_next              = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        code_reg       <= code_next;
        data_addr_reg  <= data_addr_next;
        hit_addr_reg   <= hit_addr_next;
        hit_reg        <= hit_next;
        res_status_reg <= res_status_next;
        res_active_reg <= res_active_next;
        res_occ_reg    <= res_occ_next;
        m_data_reg     <= m_data_next;
    end

endmodule

`default_nettype wire

// ===== src/fault_code_table.sv =====
// fault code table top level: config register, sequencer and entry ram
//
//  channel   ports                         direction  carries
//  input     s_valid s_ready s_data        in         op, code
//  result    m_valid m_ready m_data        out        status, hit_active, occurrences, entry_total
//  config    cfg_valid cfg_ready cfg_data  in         reserved_code
//
// one transaction at a time: accept, linear scan of the stored entries at one ram
// read per cycle, an update state and a result state; a miss scans every stored entry,
// a hit ends the scan early. clear all skips the scan and the update state; a clear of
// any entry but the last adds a move state for the ram move. the single ram read port
// sets the scan length.
// reset empties the table at once through the entry count; ram contents are not swept.
// the result register frees the sequencer while m_ready is low; a second result waits.
`timescale 1ns / 1ps
`default_nettype none

module fault_code_table (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire fct_pkg::in_item_t          s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output fct_pkg::out_item_t              m_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [fct_pkg::CODE_W-1:0] cfg_data
);

    import fct_pkg::*;

    logic [CODE_W-1:0] reserved_code_reg;
    mem_cmd_t          mem_cmd;
    entry_t            rd_data;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_code_reg <= '0;
        end else if (cfg_valid) begin
            reserved_code_reg <= cfg_data;
        end
    end

    // sequencer
    fct_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .reserved_code (reserved_code_reg),
        .mem_cmd       (mem_cmd),
        .rd_data       (rd_data)
    );

    // entry store
    fct_ram #(
        .WIDTH  ($bits(entry_t)),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_cmd.wr_en),
        .wr_addr (mem_cmd.wr_addr),
        .wr_data (mem_cmd.wr_data),
        .rd_en   (mem_cmd.rd_en),
        .rd_addr (mem_cmd.rd_addr),
        .rd_data (rd_data)
    );

`ifndef NO_ASSERTIONS
    // entry total never beyond the table size
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.entry_total <= TOTAL_W'(DEPTH)))
        else $error("entry total beyond table size");

    // a store refused for a full table reports no entry
    a_reject_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STS_FULL)
        |-> (!m_data.hit_active && m_data.occurrences == '0))
        else $error("full table store reports an entry");

    // an active entry has been seen at least once
    a_active_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.hit_active) |-> (m_data.occurrences != '0))
        else $error("active entry with zero occurrences");

    // one transaction at a time through the sequencer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a transaction is in flight");

    // ram writes stay inside the table
    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_cmd.wr_en |-> (int'(mem_cmd.wr_addr) < DEPTH))
        else $error("ram write outside the table");
`endif

endmodule

`default_nettype wire
